// ===== src/bmhq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types for the max priority queue
// Beat payloads, operation and status codes, and the per-cell command bundle.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 7;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                   kind;
    logic signed [KeyW-1:0]  key;
  } in_t;

  typedef struct packed {
    logic signed [KeyW-1:0]  removed_key;
    logic signed [KeyW-1:0]  top_key;
    logic [CountW-1:0]       entry_count;
    status_e                 status;
  } out_t;

  // Broadcast to every cell; ins/rem are already qualified by full/empty.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KeyW-1:0]  key;
  } cell_cmd_t;

endpackage

// ===== src/bmhq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_cell: one slot of the sorted shift chain
// Holds one key and its valid bit. On insert, takes the left neighbor's key
// or, at the new key's slot, the new key; on remove, the right neighbor's key.
// ----------------------------------------------------------------------------
module bmhq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bmhq_pkg::cell_cmd_t               cmd_i,
  input  logic                              left_gt_i,
  input  logic signed [bmhq_pkg::KeyW-1:0]  left_key_i,
  input  logic                              left_vld_i,
  input  logic signed [bmhq_pkg::KeyW-1:0]  right_key_i,
  input  logic                              right_vld_i,
  output logic                              gt_o,
  output logic signed [bmhq_pkg::KeyW-1:0]  key_o,
  output logic                              vld_o
);
  import bmhq_pkg::*;

  logic signed [KeyW-1:0] key_q, key_d;
  logic                   vld_q, vld_d;

  // New key belongs at or before this slot; empty slots act as minus infinity.
  assign gt_o = !vld_q || (cmd_i.key > key_q);

  always_comb begin
    key_d = key_q;
    vld_d = vld_q;
    if (cmd_i.ins && gt_o) begin
      if (left_gt_i) begin
        key_d = left_key_i;
        vld_d = left_vld_i;
      end else begin
        key_d = cmd_i.key;
        vld_d = 1'b1;
      end
    end else if (cmd_i.rem) begin
      key_d = right_key_i;
      vld_d = right_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign vld_o = vld_q;

endmodule

// ===== src/binary_max_heap_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_core: max priority queue on a chain of sorted cells
//
//   channel | direction | payload        | handshake
//   --------+-----------+----------------+---------------------
//   in      | input     | in_t (kind,key)| in_valid_i/in_ready_o
//   out     | output    | out_t          | out_valid_o/out_ready_i
//
// For each beat in, every cell compares the new key in parallel and the
// chain shifts by one slot. The result sits in an output register the cycle
// after acceptance; a new beat is taken while that register drains, so the
// sustained rate is one beat per cycle; a stalled output holds the input off.
// Reset clears all valid bits and the count; no clearing pass.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_core #(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bmhq_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bmhq_pkg::out_t  out_o
);
  import bmhq_pkg::*;

  localparam int unsigned CntW = $clog2(HEAP_DEPTH + 1);

  logic [CntW-1:0]        count_q, count_d;
  logic                   out_vld_q;
  out_t                   out_q, out_d;

  logic                   fire, full, empty, ins_ok, rem_ok;
  cell_cmd_t              cmd;
  logic [HEAP_DEPTH-1:0]  gt, vld;
  logic signed [KeyW-1:0] cell_key [HEAP_DEPTH];

  assign in_ready_o = !out_vld_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(HEAP_DEPTH));
  assign empty      = (count_q == '0);
  assign ins_ok     = fire && (in_i.kind == KIND_INSERT) && !full;
  assign rem_ok     = fire && (in_i.kind == KIND_REMOVE) && !empty;

  assign cmd.ins = ins_ok;
  assign cmd.rem = rem_ok;
  assign cmd.key = in_i.key;

  for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
    logic                   l_gt, l_vld, r_vld;
    logic signed [KeyW-1:0] l_key, r_key;
    if (i == 0) begin : g_head
      assign l_gt  = 1'b0;
      assign l_key = '0;
      assign l_vld = 1'b0;
    end else begin : g_mid
      assign l_gt  = gt[i-1];
      assign l_key = cell_key[i-1];
      assign l_vld = vld[i-1];
    end
    if (i == HEAP_DEPTH - 1) begin : g_tail
      assign r_key = '0;
      assign r_vld = 1'b0;
    end else begin : g_body
      assign r_key = cell_key[i+1];
      assign r_vld = vld[i+1];
    end
    bmhq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_gt_i   (l_gt),
      .left_key_i  (l_key),
      .left_vld_i  (l_vld),
      .right_key_i (r_key),
      .right_vld_i (r_vld),
      .gt_o        (gt[i]),
      .key_o       (cell_key[i]),
      .vld_o       (vld[i])
    );
  end

  // Result reflects the chain state after this beat.
  always_comb begin
    count_d           = count_q;
    out_d.removed_key = '0;
    out_d.status      = ST_OK;
    out_d.top_key     = vld[0] ? cell_key[0] : '0;
    if (ins_ok) begin
      count_d       = count_q + 1'b1;
      out_d.top_key = gt[0] ? in_i.key : cell_key[0];
    end else if (rem_ok) begin
      count_d           = count_q - 1'b1;
      out_d.removed_key = cell_key[0];
      out_d.top_key     = vld[1] ? cell_key[1] : '0;
    end else if (in_i.kind == KIND_INSERT) begin
      out_d.status = ST_FULL;
    end else begin
      out_d.status = ST_EMPTY;
    end
    out_d.entry_count = CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // Count and the head/tail valid bits must agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty == !vld[0])
    else $error("count empty but head cell valid, or the reverse");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   full == vld[HEAP_DEPTH-1])
    else $error("count full disagrees with tail cell valid");
  // Chain stays sorted at the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   vld[1] |-> !(cell_key[1] > cell_key[0]))
    else $error("second cell larger than head");
  // An accepted beat always yields a result the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fire |=> out_vld_q)
    else $error("accepted beat produced no result");

endmodule
